### rtl/core/fpcf_pkg.sv
// Shared types, constants and register indexes of the filtered position coupling force block.
// No dependencies. Every other file of the block but fpcf_ram imports this package.
`default_nettype none

package fpcf_pkg;

  localparam int MAX_WINDOW_DEF = 8;

  localparam int POS_W   = 16;
  localparam int FORCE_W = 32;
  localparam int GAIN_W  = 16;
  localparam int SCALE_W = 16;
  localparam int WLEN_W  = 4;
  localparam int K_W     = GAIN_W + SCALE_W;
  localparam int DIFF_W  = POS_W + 1;
  localparam int PROD_W  = K_W + 1 + DIFF_W;
  localparam int FRAC_SH = 16;

  // window_len never exceeds 15, so the sum of a window fits in 36 bits
  localparam int DIV_W     = WLEN_W;
  localparam int ACC_W     = FORCE_W + WLEN_W;
  localparam int DIV_STEPS = ACC_W / 2;
  localparam int DIVC_W    = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COUPLING_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN      = 2'd2;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd655;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
  localparam logic [WLEN_W-1:0]  WLEN_RESET  = 4'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_a_x;
    logic signed [POS_W-1:0] pos_a_y;
    logic signed [POS_W-1:0] pos_a_z;
    logic signed [POS_W-1:0] pos_b_x;
    logic signed [POS_W-1:0] pos_b_y;
    logic signed [POS_W-1:0] pos_b_z;
  } fpcf_in_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_mean_x;
    logic signed [FORCE_W-1:0] force_mean_y;
    logic signed [FORCE_W-1:0] force_mean_z;
  } fpcf_out_t;

  typedef struct packed {
    logic       load_in;
    logic       load_k;
    logic       mul_en;
    logic       sat_en;
    logic [1:0] axis;
    logic       wr_en;
    logic       rd_en;
    logic       div_start;
    logic       div_step;
    logic       out_load;
  } fpcf_cmd_t;

  typedef struct packed {
    logic rd_last;
    logic out_busy;
  } fpcf_status_t;

endpackage

`default_nettype wire

### rtl/core/filtered_position_coupling_force.sv
// Top level of the filtered position coupling force block: sequencer plus datapath.
// Depends on fpcf_pkg, fpcf_ctrl, fpcf_datapath and fpcf_ram.
//
// Each transaction carries the positions of two three-axis devices; the block forms
// the spring force -(gain * scale * (a - b)) >> 16 per axis, saturated to 32 bits,
// writes it into a ring over the first n of MAX_WINDOW rows and returns the per-axis mean of those
// n rows, n being window_len held within 1 and MAX_WINDOW, truncated toward zero.
// One transaction is worked at a time; from acceptance to the result register it passes
// through the shared force multiplier once per axis, n reads from the sample memory and
// the two-bit-per-cycle divider, with one quotient lane for each axis.
// A new transaction is accepted while the previous result waits to be taken. Rows
// never written read as zero through per-row valid bits, so no clearing pass follows
// reset. Configuration writes are always taken and belong in idle periods.
`default_nettype none

module filtered_position_coupling_force import fpcf_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire fpcf_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output fpcf_out_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  fpcf_cmd_t    cmd;
  fpcf_status_t status;

  assign cfg_ready = 1'b1;

  fpcf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  fpcf_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register loaded while still occupied");

  // one transaction at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again while a transaction is in flight");

  // a new result appears only from a load of the result register
  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result valid rose without a load");

  // the sequencer issues at most one major step per cycle
  a_single_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_in, cmd.load_k, cmd.mul_en, cmd.sat_en, cmd.wr_en,
              cmd.rd_en, cmd.div_start, cmd.div_step, cmd.out_load}))
    else $error("more than one datapath step commanded");

endmodule

`default_nettype wire

### rtl/core/fpcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fpcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/fpcf_ctrl.sv
// Sequencer of the filtered position coupling force block.
// Depends on fpcf_pkg; drives the datapath through fpcf_cmd_t.
`default_nettype none

module fpcf_ctrl import fpcf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output fpcf_cmd_t         cmd,
  input  wire fpcf_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_KMUL,
    S_MUL,
    S_SAT,
    S_WRITE,
    S_READ,
    S_DRAIN,
    S_DIVLD,
    S_DIV,
    S_FINISH
  } state_t;

  state_t             state;
  logic [1:0]         axis;
  logic [DIVC_W-1:0]  div_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      axis    <= AXIS_X;
      div_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_KMUL;
          end
        end
        S_KMUL: begin
          axis  <= AXIS_X;
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_SAT;
        end
        S_SAT: begin
          if (axis == AXIS_Z) begin
            state <= S_WRITE;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_MUL;
          end
        end
        S_WRITE: begin
          state <= S_READ;
        end
        S_READ: begin
          if (status.rd_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DIVLD;
        end
        S_DIVLD: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + DIVC_W'(1);
          if (div_cnt == DIVC_W'(DIV_STEPS - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (!status.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.axis      = axis;
    cmd.load_in   = (state == S_IDLE) && in_valid;
    cmd.load_k    = (state == S_KMUL);
    cmd.mul_en    = (state == S_MUL);
    cmd.sat_en    = (state == S_SAT);
    cmd.wr_en     = (state == S_WRITE);
    cmd.rd_en     = (state == S_READ);
    cmd.div_start = (state == S_DIVLD);
    cmd.div_step  = (state == S_DIV);
    cmd.out_load  = (state == S_FINISH) && !status.out_busy;
  end

endmodule

`default_nettype wire

### rtl/core/fpcf_datapath.sv
// Datapath: configuration registers, force multiplier and saturation, sample memory,
// window accumulators, three-lane divider and output register.
// Depends on fpcf_pkg and fpcf_ram.
`default_nettype none

module fpcf_datapath import fpcf_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire fpcf_in_t              in_data,
  input  wire fpcf_cmd_t             cmd,
  output fpcf_status_t               status,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output fpcf_out_t                  out_data
);

  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int ROW_W  = 3 * FORCE_W;

  logic [GAIN_W-1:0]  coupling_gain;
  logic [SCALE_W-1:0] stiffness_scale;
  logic [WLEN_W-1:0]  window_len;
  logic [CNT_W-1:0]   n_eff;

  fpcf_in_t                   in_q;
  logic [K_W-1:0]             k_q;
  logic signed [K_W:0]        k_s;
  logic signed [POS_W-1:0]    pa;
  logic signed [POS_W-1:0]    pb;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [PROD_W:0]     neg;
  logic signed [PROD_W:0]     shifted;
  logic signed [FORCE_W-1:0]  sat_val;
  logic signed [FORCE_W-1:0]  force_q [3];

  logic [SLOT_W-1:0]     slot;
  logic [SLOT_W:0]       slot_inc;
  logic [MAX_WINDOW-1:0] slot_valid;
  logic [SLOT_W-1:0]     rd_idx;
  logic                  rd_pend;
  logic                  rd_vld;
  logic [ROW_W-1:0]      rd_row;

  logic signed [ACC_W-1:0] acc  [3];
  logic [ACC_W-1:0]        dvd  [3];
  logic [DIV_W-1:0]        rem  [3];
  logic                    sgn  [3];
  logic [FORCE_W-1:0]      mean [3];
  logic [DIV_W-1:0]        divisor;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      coupling_gain   <= GAIN_RESET;
      stiffness_scale <= SCALE_RESET;
      window_len      <= WLEN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COUPLING_GAIN:   coupling_gain   <= cfg_data;
        REG_STIFFNESS_SCALE: stiffness_scale <= cfg_data;
        REG_WINDOW_LEN:      window_len      <= cfg_data[WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (window_len == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(window_len) > 32'(MAX_WINDOW)) begin
      n_eff = CNT_W'(MAX_WINDOW);
    end else begin
      n_eff = CNT_W'(window_len);
    end
  end

  // force sample per axis: multiply, then negate, floor shift and saturate
  always_comb begin
    case (cmd.axis)
      AXIS_X: begin
        pa = in_q.pos_a_x;
        pb = in_q.pos_b_x;
      end
      AXIS_Y: begin
        pa = in_q.pos_a_y;
        pb = in_q.pos_b_y;
      end
      default: begin
        pa = in_q.pos_a_z;
        pb = in_q.pos_b_z;
      end
    endcase
    diff    = DIFF_W'(pa) - DIFF_W'(pb);
    k_s     = signed'({1'b0, k_q});
    neg     = -((PROD_W + 1)'(prod_q));
    shifted = neg >>> FRAC_SH;
    if (shifted[PROD_W:FORCE_W-1] == '0 || shifted[PROD_W:FORCE_W-1] == '1) begin
      sat_val = shifted[FORCE_W-1:0];
    end else if (shifted[PROD_W]) begin
      sat_val = {1'b1, {(FORCE_W - 1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(FORCE_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_q <= in_data;
    end
    if (cmd.load_k) begin
      k_q <= K_W'(coupling_gain) * K_W'(stiffness_scale);
    end
    if (cmd.mul_en) begin
      prod_q <= PROD_W'(k_s) * PROD_W'(diff);
    end
    if (cmd.sat_en) begin
      case (cmd.axis)
        AXIS_X:  force_q[0] <= sat_val;
        AXIS_Y:  force_q[1] <= sat_val;
        default: force_q[2] <= sat_val;
      endcase
    end
  end

  // ring write index, entry valid bits and read sweep
  assign slot_inc = {1'b0, slot} + (SLOT_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot       <= '0;
      slot_valid <= '0;
      rd_idx     <= '0;
      rd_pend    <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en;
      if (cmd.wr_en) begin
        slot_valid[slot] <= 1'b1;
        rd_idx           <= '0;
        if (32'(slot_inc) >= 32'(n_eff)) begin
          slot <= '0;
        end else begin
          slot <= slot_inc[SLOT_W-1:0];
        end
      end else if (cmd.rd_en) begin
        rd_idx <= rd_idx + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_vld <= slot_valid[rd_idx];
    end
  end

  assign status.rd_last  = (32'(rd_idx) == 32'(n_eff) - 32'd1);
  assign status.out_busy = out_valid && !out_ready;

  fpcf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_WINDOW)
  ) u_samples (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (slot),
    .wdata ({force_q[2], force_q[1], force_q[0]}),
    .re    (cmd.rd_en),
    .raddr (rd_idx),
    .rdata (rd_row)
  );

  // two restoring steps per cycle; the remainder stays below the divisor
  function automatic logic [DIV_W+ACC_W-1:0] div_pair(
    input logic [DIV_W-1:0] r_in,
    input logic [ACC_W-1:0] q_in,
    input logic [DIV_W-1:0] d
  );
    logic [DIV_W:0]   t;
    logic [DIV_W-1:0] r;
    logic [ACC_W-1:0] q;
    r = r_in;
    q = q_in;
    for (int b = 0; b < 2; b++) begin
      t = {r, q[ACC_W-1]};
      q = {q[ACC_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t    = t - {1'b0, d};
        q[0] = 1'b1;
      end
      r = t[DIV_W-1:0];
    end
    return {r, q};
  endfunction

  assign divisor = DIV_W'(n_eff);

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [FORCE_W-1:0] sample;
    logic [FORCE_W-1:0]        q32;

    assign sample  = rd_row[i*FORCE_W +: FORCE_W];
    assign q32     = dvd[i][FORCE_W-1:0];
    assign mean[i] = sgn[i] ? (~q32 + FORCE_W'(1)) : q32;

    always_ff @(posedge clk) begin
      if (cmd.wr_en) begin
        acc[i] <= '0;
      end else if (rd_pend && rd_vld) begin
        acc[i] <= acc[i] + ACC_W'(sample);
      end
      if (cmd.div_start) begin
        sgn[i] <= acc[i][ACC_W-1];
        dvd[i] <= acc[i][ACC_W-1] ? ACC_W'(-acc[i]) : ACC_W'(acc[i]);
        rem[i] <= '0;
      end else if (cmd.div_step) begin
        {rem[i], dvd[i]} <= div_pair(rem[i], dvd[i], divisor);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.force_mean_x <= mean[0];
      out_data.force_mean_y <= mean[1];
      out_data.force_mean_z <= mean[2];
    end
  end

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for filtered_position_coupling_force: per-axis spring force and window mean.
// Depends on fpcf_pkg and the block's top level, with the files that the top level needs.
`timescale 1ns / 1ps

module testbench;
  import fpcf_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int TOTAL_ITEMS    = 650;
  localparam int CALM_ITEMS     = 80;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int MAX_WIN        = MAX_WINDOW_DEF;

  // index 3 decodes to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  fpcf_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  fpcf_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_COUPLING_GAIN;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  filtered_position_coupling_force dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Register copies and sample rings of the force model
  logic [GAIN_W-1:0]  gain_shadow  = GAIN_RESET;
  logic [SCALE_W-1:0] scale_shadow = SCALE_RESET;
  logic [WLEN_W-1:0]  wlen_shadow  = WLEN_RESET;
  longint             force_ring [3][MAX_WIN];
  int unsigned        ring_slot = 0;

  fpcf_in_t  pending_positions [$];
  fpcf_out_t expected_means [$];

  int items_queued    = 0;
  int items_accepted  = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int error_count     = 0;

  int   send_idle_odds = 0;
  int   recv_idle_odds = 0;
  int   send_gap       = 0;
  int   stall_left     = 0;
  logic holdoff_go     = 1'b0;
  logic hold_results   = 1'b0;
  int   idle_cycles    = 0;

  initial begin
    for (int ax = 0; ax < 3; ax++) begin
      for (int i = 0; i < MAX_WIN; i++) begin
        force_ring[ax][i] = 0;
      end
    end
  end

  // Write the new force samples into the rings and return the per-axis window means
  function automatic fpcf_out_t predict_mean(input fpcf_in_t pos);
    longint      k, f, total;
    longint      avg [3];
    longint      pa [3];
    longint      pb [3];
    int unsigned n;
    fpcf_out_t   mean;
    pa[AXIS_X] = longint'(pos.pos_a_x);
    pa[AXIS_Y] = longint'(pos.pos_a_y);
    pa[AXIS_Z] = longint'(pos.pos_a_z);
    pb[AXIS_X] = longint'(pos.pos_b_x);
    pb[AXIS_Y] = longint'(pos.pos_b_y);
    pb[AXIS_Z] = longint'(pos.pos_b_z);
    n = (wlen_shadow == 0) ? 1 : (wlen_shadow > MAX_WIN) ? MAX_WIN : int'(wlen_shadow);
    if (ring_slot >= MAX_WIN) ring_slot = 0;
    k = longint'(gain_shadow) * longint'(scale_shadow);
    for (int ax = 0; ax < 3; ax++) begin
      f = (-(k * (pa[ax] - pb[ax]))) >>> FRAC_SH;
      if (f > longint'(32'sh7FFF_FFFF)) f = longint'(32'sh7FFF_FFFF);
      if (f < -longint'(32'sh7FFF_FFFF) - 1) f = -longint'(32'sh7FFF_FFFF) - 1;
      force_ring[ax][ring_slot] = f;
    end
    ring_slot++;
    if (ring_slot >= n) ring_slot = 0;
    for (int ax = 0; ax < 3; ax++) begin
      total = 0;
      for (int i = 0; i < int'(n); i++) total += force_ring[ax][i];
      avg[ax] = total / longint'(n);
    end
    mean.force_mean_x = 32'(avg[AXIS_X]);
    mean.force_mean_y = 32'(avg[AXIS_Y]);
    mean.force_mean_z = 32'(avg[AXIS_Z]);
    return mean;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    error_count++;
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, results_checked, got, want);
  endtask

  // Position driver: offer queued transactions, predict on acceptance
  always @(posedge clk) begin : position_driver
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        expected_means.push_back(predict_mean(in_data));
        items_accepted++;
        offer = 1'b0;
        if (send_idle_odds != 0 && $urandom_range(1, send_idle_odds) == 1)
          send_gap = $urandom_range(1, 14);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_positions.size() != 0) begin
          in_data <= pending_positions.pop_front();
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // Result receiver: random stalls, plus the long hold-off when asked
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (recv_idle_odds != 0 && $urandom_range(1, recv_idle_odds) == 1) begin
      stall_left = $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_results;
    end
  end

  initial begin : long_holdoff
    wait (holdoff_go);
    @(posedge clk);
    hold_results <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  // Result monitor
  always @(posedge clk) begin : force_monitor
    fpcf_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_means.size() == 0) begin
        report_mismatch("unexpected result x", out_data.force_mean_x, 0);
      end else begin
        want = expected_means.pop_front();
        if (out_data.force_mean_x !== want.force_mean_x)
          report_mismatch("force_mean_x", out_data.force_mean_x, want.force_mean_x);
        if (out_data.force_mean_y !== want.force_mean_y)
          report_mismatch("force_mean_y", out_data.force_mean_y, want.force_mean_y);
        if (out_data.force_mean_z !== want.force_mean_z)
          report_mismatch("force_mean_z", out_data.force_mean_z, want.force_mean_z);
      end
      results_checked++;
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_COUPLING_GAIN:   gain_shadow  = val;
      REG_STIFFNESS_SCALE: scale_shadow = val;
      REG_WINDOW_LEN:      wlen_shadow  = val[WLEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_positions(input logic [15:0] ax, ay, az, bx, by, bz);
    pending_positions.push_back({ax, ay, az, bx, by, bz});
    items_queued++;
  endtask

  function automatic logic [15:0] pick_position();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_coeff(input logic [15:0] dflt);
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return dflt;
      3: return 16'($urandom_range(1, 1024));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int count);
    logic [15:0] pa [3];
    logic [15:0] pb [3];
    for (int i = 0; i < count; i++) begin
      for (int ax = 0; ax < 3; ax++) begin
        pa[ax] = pick_position();
        // devices that track each other closely are the common case
        if ($urandom_range(0, 2) == 0)
          pb[ax] = pa[ax] + 16'($urandom_range(0, 64)) - 16'd32;
        else
          pb[ax] = pick_position();
      end
      queue_positions(pa[0], pa[1], pa[2], pb[0], pb[1], pb[2]);
    end
  endtask

  // Hold until every queued transaction has produced its result
  task automatic drain();
    @(negedge clk);
    while (pending_positions.size() != 0 || in_valid || expected_means.size() != 0)
      @(negedge clk);
  endtask

  initial begin : stimulus
    int phase;
    int phase_items;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    send_idle_odds = 4;
    recv_idle_odds = 4;

    // Reset settings: extremes of the position difference
    queue_positions(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_positions(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
    queue_positions(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_positions(16'h04D2, 16'hFB2E, 16'h7FFF, 16'h04D2, 16'hFB2E, 16'h7FFF);
    queue_positions(16'h7FFF, 16'h8000, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF);
    drain();

    // Largest gain and scale: forces saturate both ways
    write_reg(REG_COUPLING_GAIN, 16'hFFFF);
    write_reg(REG_STIFFNESS_SCALE, 16'hFFFF);
    write_reg(REG_WINDOW_LEN, 16'h0001);
    queue_positions(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
    queue_positions(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_positions(16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
    queue_positions(16'h7FFF, 16'h0100, 16'h8000, 16'h8000, 16'hFF00, 16'h7FFF);
    drain();
    write_reg(REG_COUPLING_GAIN, 16'h0000);
    queue_positions(16'h7FFF, 16'h8000, 16'h1234, 16'h8000, 16'h7FFF, 16'hEDCC);
    drain();

    // Zero window acts as one, oversized window as the full ring
    write_reg(REG_COUPLING_GAIN, GAIN_RESET);
    write_reg(REG_STIFFNESS_SCALE, SCALE_RESET);
    write_reg(REG_WINDOW_LEN, 16'h0000);
    queue_positions(16'h1000, 16'h8000, 16'h7FFF, 16'hF000, 16'h0000, 16'h0000);
    queue_positions(16'h0200, 16'h0300, 16'hFC00, 16'h0000, 16'h0000, 16'h0000);
    drain();
    write_reg(REG_WINDOW_LEN, 16'hFFFF);
    queue_positions(16'h7FFF, 16'h8000, 16'h4000, 16'h8000, 16'h7FFF, 16'hC000);
    queue_positions(16'h0123, 16'hFEDC, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0);
    drain();

    // Advance the write slot near the top, then shrink the window below it
    write_reg(REG_WINDOW_LEN, 16'h0008);
    queue_random(5);
    drain();
    write_reg(REG_WINDOW_LEN, 16'h0002);
    queue_random(2);
    drain();

    // Write to the unused index: nothing may change
    write_reg(REG_UNUSED, 16'hFFFF);
    queue_positions(16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    drain();

    phase = 0;
    while (items_queued < TOTAL_ITEMS) begin
      drain();
      if (items_queued >= TOTAL_ITEMS - CALM_ITEMS) begin
        send_idle_odds = 0;
        recv_idle_odds = 0;
      end else begin
        send_idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
        recv_idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
      end
      if ($urandom_range(0, 2) != 0) write_reg(REG_COUPLING_GAIN, pick_coeff(GAIN_RESET));
      if ($urandom_range(0, 2) != 0) write_reg(REG_STIFFNESS_SCALE, pick_coeff(SCALE_RESET));
      if ($urandom_range(0, 2) != 0)
        write_reg(REG_WINDOW_LEN, {12'($urandom), 4'($urandom_range(0, 15))});
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 16'($urandom));
      phase_items = $urandom_range(30, 70);
      // stall results for a long stretch while positions keep coming
      if (phase == 2) holdoff_go = 1'b1;
      queue_random(phase_items);
      phase++;
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d position transactions over %0d random phases, %0d register writes",
             items_accepted, phase, reg_writes);
    $display("summary: %0d window means checked, %0d mismatches", results_checked, error_count);
    if (error_count == 0 && expected_means.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
